[hw/rtl/dhcp_option_stream_parser_macros.svh]
// ============================================================================
// DHCP option stream parser assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ============================================================================
`ifndef DHCP_OPTION_STREAM_PARSER_MACROS_SVH
`define DHCP_OPTION_STREAM_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define DOSP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition must never be true outside reset
`define DOSP_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define DOSP_ASSERT(label, clk, rst, prop, msg)
`define DOSP_ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

[hw/rtl/dosp_pkg.sv]
// ----------------------------------------------------------------------------
// dosp_pkg
// Types and constants shared by the DHCP option stream parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dosp_pkg;

   // region size and derived widths
   localparam int REGION_BYTES = 1024;
   localparam int OFFSET_W     = $clog2(REGION_BYTES + 1);
   localparam int START_W      = $clog2(REGION_BYTES);
   localparam int OPT_OFFSET_W = 10;

   localparam logic [OFFSET_W-1:0] LAST_OFFSET  = OFFSET_W'(REGION_BYTES - 1);
   localparam logic [OFFSET_W-1:0] REGION_LIMIT = OFFSET_W'(REGION_BYTES);

   // special option codes
   localparam logic [7:0] PAD_CODE = 8'd0;
   localparam logic [7:0] END_CODE = 8'd255;

   // block step after the final overload move
   localparam logic [1:0] BLOCK_STEP_LAST = 2'd3;

   typedef enum logic [1:0] {
      REGION_OPTIONS = 2'd0,
      REGION_FILE    = 2'd1,
      REGION_SNAME   = 2'd2
   } region_type;

   typedef enum logic [1:0] {
      PHASE_CODE = 2'd0,
      PHASE_LEN  = 2'd1,
      PHASE_DATA = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      STATUS_END       = 2'd0,
      STATUS_EXHAUSTED = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   // one accepted input byte
   typedef struct packed {
      logic [7:0] data_byte;
      logic [1:0] region;
      logic       region_last;
      logic       msg_start;
   } item_type;

   // one result transaction
   typedef struct packed {
      logic                    option_valid;
      logic [7:0]              option_code;
      logic [7:0]              option_length;
      logic [OPT_OFFSET_W-1:0] option_offset;
      logic [1:0]              option_region;
      logic                    parse_done;
      logic [1:0]              done_status;
   } result_type;

endpackage

`default_nettype wire

[hw/rtl/dosp_req_if.sv]
// ----------------------------------------------------------------------------
// dosp_req_if
// Input byte channel: valid/ready with the tagged option byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dosp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic [1:0] region;
   logic       region_last;
   logic       msg_start;

   modport source (
      output valid, data_byte, region, region_last, msg_start,
      input  ready
   );

   modport sink (
      input  valid, data_byte, region, region_last, msg_start,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/dosp_rsp_if.sv]
// ----------------------------------------------------------------------------
// dosp_rsp_if
// Result channel: valid/ready with option report and parse status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface dosp_rsp_if;
   logic       valid;
   logic       ready;
   logic       option_valid;
   logic [7:0] option_code;
   logic [7:0] option_length;
   logic [9:0] option_offset;
   logic [1:0] option_region;
   logic       parse_done;
   logic [1:0] done_status;

   modport source (
      output valid, option_valid, option_code, option_length, option_offset,
      output option_region, parse_done, done_status,
      input  ready
   );

   modport sink (
      input  valid, option_valid, option_code, option_length, option_offset,
      input  option_region, parse_done, done_status,
      output ready
   );
endinterface

`default_nettype wire

[hw/rtl/dosp_in_stage.sv]
// ----------------------------------------------------------------------------
// dosp_in_stage
// Input register: captures one byte transaction and holds it for the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dosp_in_stage
   import dosp_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   dosp_req_if.sink  req_bus,
   input  wire logic item_take,
   output logic      item_valid,
   output item_type  item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     load;

   // free slot, or the held byte leaves this cycle
   assign req_bus.ready = !valid_ff || item_take;
   assign load          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.data_byte   <= req_bus.data_byte;
         item_ff.region      <= req_bus.region;
         item_ff.region_last <= req_bus.region_last;
         item_ff.msg_start   <= req_bus.msg_start;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

[hw/rtl/dosp_parse.sv]
// ----------------------------------------------------------------------------
// dosp_parse
// Option TLV state: phase, region chain, offsets and held option fields.
// Decides per byte whether an option completes or the parse ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "dhcp_option_stream_parser_macros.svh"

module dosp_parse
   import dosp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_write_data,
   input  wire logic       item_valid,
   input  wire item_type   item,
   input  wire logic       out_free,
   output logic            item_take,
   output logic            result_valid,
   output result_type      result
);

   // configuration
   logic [1:0] overload_ff;

   // parse state
   phase_type           phase_ff,    phase_in,    cur_phase;
   region_type          region_ff,   region_in,   cur_region;
   logic [1:0]          step_ff,     step_in,     cur_step;
   logic [OFFSET_W-1:0] offset_ff,   offset_in,   cur_offset;
   logic [START_W-1:0]  start_ff,    start_in,    cur_start;
   logic [7:0]          code_ff,     code_in,     cur_code;
   logic [7:0]          len_ff,      len_in,      cur_len;
   logic [7:0]          left_ff,     left_in,     cur_left;
   logic                finished_ff, finished_in, cur_finished;

   logic       region_match;
   logic       is_last;
   logic       move;
   logic       opt;
   logic       done;
   status_type status_s;
   logic [1:0] step_next;
   logic [7:0] left_dec;

   // overload register
   always_ff @(posedge clock) begin
      if (reset) begin
         overload_ff <= 2'd0;
      end else if (csr_write_enable) begin
         overload_ff <= csr_write_data;
      end
   end

   // next state and result for the held byte
   always_comb begin
      // message start clears the parse before the byte is handled
      cur_phase    = phase_ff;
      cur_region   = region_ff;
      cur_step     = step_ff;
      cur_offset   = offset_ff;
      cur_start    = start_ff;
      cur_code     = code_ff;
      cur_len      = len_ff;
      cur_left     = left_ff;
      cur_finished = finished_ff;
      if (item.msg_start) begin
         cur_phase    = PHASE_CODE;
         cur_region   = REGION_OPTIONS;
         cur_step     = 2'd0;
         cur_offset   = '0;
         cur_start    = '0;
         cur_code     = 8'd0;
         cur_len      = 8'd0;
         cur_left     = 8'd0;
         cur_finished = 1'b0;
      end

      phase_in    = cur_phase;
      region_in   = cur_region;
      step_in     = cur_step;
      offset_in   = cur_offset;
      start_in    = cur_start;
      code_in     = cur_code;
      len_in      = cur_len;
      left_in     = cur_left;
      finished_in = cur_finished;

      move      = 1'b0;
      opt       = 1'b0;
      done      = 1'b0;
      status_s  = STATUS_END;
      step_next = cur_step + 2'd1;
      left_dec  = cur_left - 8'd1;

      is_last      = item.region_last || (cur_offset >= LAST_OFFSET);
      region_match = !cur_finished && (item.region == cur_region);

      if (region_match) begin
         case (cur_phase)
            PHASE_CODE: begin
               if (item.data_byte == PAD_CODE) begin
                  if (is_last) begin
                     done     = 1'b1;
                     status_s = STATUS_EXHAUSTED;
                  end
               end else if (item.data_byte == END_CODE) begin
                  if (cur_step < overload_ff) begin
                     // overload: move to file and/or server name, file first
                     move      = 1'b1;
                     offset_in = '0;
                     if (overload_ff[0] && step_next[0]) begin
                        region_in = REGION_FILE;
                        step_in   = step_next;
                     end else begin
                        region_in = REGION_SNAME;
                        step_in   = BLOCK_STEP_LAST;
                     end
                  end else begin
                     done     = 1'b1;
                     status_s = STATUS_END;
                  end
               end else begin
                  code_in  = item.data_byte;
                  start_in = cur_offset[START_W-1:0];
                  if (is_last) begin
                     done     = 1'b1;
                     status_s = STATUS_TRUNCATED;
                  end else begin
                     phase_in = PHASE_LEN;
                  end
               end
            end
            PHASE_LEN: begin
               len_in = item.data_byte;
               if (item.data_byte == 8'd0) begin
                  opt      = 1'b1;
                  phase_in = PHASE_CODE;
                  if (is_last) begin
                     done     = 1'b1;
                     status_s = STATUS_EXHAUSTED;
                  end
               end else begin
                  left_in = item.data_byte;
                  if (is_last) begin
                     done     = 1'b1;
                     status_s = STATUS_TRUNCATED;
                  end else begin
                     phase_in = PHASE_DATA;
                  end
               end
            end
            PHASE_DATA: begin
               left_in = left_dec;
               if (left_dec == 8'd0) begin
                  opt      = 1'b1;
                  phase_in = PHASE_CODE;
                  if (is_last) begin
                     done     = 1'b1;
                     status_s = STATUS_EXHAUSTED;
                  end
               end else if (is_last) begin
                  done     = 1'b1;
                  status_s = STATUS_TRUNCATED;
               end
            end
            default: begin
               phase_in = PHASE_CODE;
            end
         endcase

         // offset advances and saturates at the region size
         if (!move && (cur_offset < REGION_LIMIT)) begin
            offset_in = cur_offset + OFFSET_W'(1);
         end
         if (done) begin
            finished_in = 1'b1;
         end
      end
   end

   // result fields; option fields zero unless an option completes
   always_comb begin
      result = '0;
      if (opt) begin
         result.option_valid  = 1'b1;
         result.option_code   = code_in;
         result.option_length = len_in;
         result.option_offset = OPT_OFFSET_W'(start_in);
         result.option_region = region_in;
      end
      if (done) begin
         result.parse_done  = 1'b1;
         result.done_status = status_s;
      end
   end

   // a byte with a result waits for room in the output register
   assign result_valid = item_valid && (opt || done);
   assign item_take    = item_valid && (!(opt || done) || out_free);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_CODE;
         region_ff   <= REGION_OPTIONS;
         step_ff     <= 2'd0;
         offset_ff   <= '0;
         start_ff    <= '0;
         code_ff     <= 8'd0;
         len_ff      <= 8'd0;
         left_ff     <= 8'd0;
         finished_ff <= 1'b0;
      end else if (item_take) begin
         phase_ff    <= phase_in;
         region_ff   <= region_in;
         step_ff     <= step_in;
         offset_ff   <= offset_in;
         start_ff    <= start_in;
         code_ff     <= code_in;
         len_ff      <= len_in;
         left_ff     <= left_in;
         finished_ff <= finished_in;
      end
   end

   // a finished parse yields nothing until the next message start
   `DOSP_ASSERT(a_quiet_when_finished, clock, reset,
      (item_valid && finished_ff && !item.msg_start) |-> !result_valid,
      "result produced after parse finished")
   // every result carries an option, a status, or both
   `DOSP_ASSERT(a_result_nonempty, clock, reset,
      result_valid |-> (result.option_valid || result.parse_done),
      "empty result produced")
   // a status result leaves the parse finished
   `DOSP_ASSERT(a_done_sets_finished, clock, reset,
      (item_take && result_valid && result.parse_done) |=> finished_ff,
      "parse not finished after status")
   // data phase always has bytes outstanding
   `DOSP_ASSERT_NEVER(a_data_count_live, clock, reset,
      (phase_ff == PHASE_DATA) && (left_ff == 8'd0),
      "data phase with zero bytes left")

endmodule

`default_nettype wire

[hw/rtl/dosp_out_stage.sv]
// ----------------------------------------------------------------------------
// dosp_out_stage
// Result register: holds one result transaction until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dosp_out_stage
   import dosp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_take,
   input  wire logic       result_valid,
   input  wire result_type result,
   output logic            out_free,
   dosp_rsp_if.source      rsp_bus
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   logic       load;

   assign load     = item_take && result_valid;
   assign out_free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.option_valid  = result_ff.option_valid;
   assign rsp_bus.option_code   = result_ff.option_code;
   assign rsp_bus.option_length = result_ff.option_length;
   assign rsp_bus.option_offset = result_ff.option_offset;
   assign rsp_bus.option_region = result_ff.option_region;
   assign rsp_bus.parse_done    = result_ff.parse_done;
   assign rsp_bus.done_status   = result_ff.done_status;

endmodule

`default_nettype wire

[hw/rtl/dhcp_option_stream_parser.sv]
// ----------------------------------------------------------------------------
// dhcp_option_stream_parser
// Parses DHCP option bytes across the options, file and server-name
// regions, reporting each option and the end-of-parse status.
//
//   port       dir   width  transaction
//   req_bus    in    12     one option byte with region, last and start tags
//   rsp_bus    out   32     option report and/or parse status
//   csr_*      in    2      overload mode write
//
// One byte per cycle unless a byte with a result waits for the result register:
// a byte is held in the input register, is parsed by the logic in front of the
// result register and leaves. Its result is registered in the result register
// and held there until the sink takes it.
// Reset is synchronous and clears all parse state and the overload mode.
// A stalled result blocks only bytes that produce a result; bytes without
// one keep flowing while the result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhcp_option_stream_parser
   import dosp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   dosp_req_if.sink        req_bus,
   dosp_rsp_if.source      rsp_bus,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_write_data
);

   logic       item_valid;
   item_type   item;
   logic       item_take;
   logic       result_valid;
   result_type result;
   logic       out_free;

   dosp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .item_take  (item_take),
      .item_valid (item_valid),
      .item       (item)
   );

   dosp_parse u_parse (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item             (item),
      .out_free         (out_free),
      .item_take        (item_take),
      .result_valid     (result_valid),
      .result           (result)
   );

   dosp_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .item_take    (item_take),
      .result_valid (result_valid),
      .result       (result),
      .out_free     (out_free),
      .rsp_bus      (rsp_bus)
   );

endmodule

`default_nettype wire
